// ----- design/mos_pkg.sv -----
// ----------------------------------------------------------------------------
// mos_pkg
// Shared constants and types for the median-of-set selector.
// ----------------------------------------------------------------------------
package mos_pkg;

  // default sizing of the sorted chain
  localparam int DEF_MAX_SET    = 64;
  localparam int DEF_VALUE_BITS = 32;

  // fixed port widths
  localparam int SAMPLE_W = 32;
  localparam int SIZE_W   = 7;

  // width of the first level of the readout mux tree
  localparam int GRP_SIZE = 8;

  // sequencer states
  typedef enum logic [1:0] {
    ST_RUN,   // accepting samples into the chain
    ST_GRP,   // first readout level: pick one entry per group
    ST_SEL    // second readout level: pick the group, load output word
  } mos_state_t;

endpackage

// ----- design/mos_cell.sv -----
// ----------------------------------------------------------------------------
// mos_cell
// One slot of the insertion chain. Holds one sorted value and takes either
// its left neighbor's value or the incoming sample when a sample is inserted.
// ----------------------------------------------------------------------------
module mos_cell
  import mos_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int CW         = 7
) (
  input  logic                         clk,
  input  logic                         ins_en,     // sample accepted and chain not full
  input  logic signed [VALUE_BITS-1:0] ins_val,    // sample being inserted
  input  logic [CW-1:0]                count,      // values held before insertion
  input  logic signed [VALUE_BITS-1:0] prev_val,   // left neighbor's value
  input  logic                         prev_gt,    // left neighbor moves right
  output logic signed [VALUE_BITS-1:0] val,
  output logic                         gt          // this slot holds a larger value
);

  logic signed [VALUE_BITS-1:0] val_r;
  logic signed [VALUE_BITS-1:0] val_nxt;
  logic                         occ;
  logic                         at_end;
  logic                         wr_en;

  // occupancy from the fill count; equal values stay put
  assign occ    = count > CW'(IDX);
  assign at_end = count == CW'(IDX);
  assign gt     = occ && (val_r > ins_val);

  // shift right where the sample goes before us, or take it at its place
  assign wr_en   = ins_en && (gt || at_end);
  assign val_nxt = prev_gt ? prev_val : ins_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// ----- design/median_of_set_selector_top.sv -----
// ----------------------------------------------------------------------------
// median_of_set_selector_top
// Keeps one pixel's set of values sorted in a chain of insertion cells and
// emits the element at index count/2 on the last value of each set.
// ----------------------------------------------------------------------------
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  input   | in_valid, in_stall, in_sample, in_last_of_set    | in
//  result  | out_valid, out_stall, out_median, out_set_size,  | out
//          | out_overflow                                     |
//
//  Words stream into the chain at one per cycle within a set. After the last
//  word of a set the two levels of the registered mux tree over the chain
//  are read out (ST_GRP, then ST_SEL), and the input is stalled during both
//  readout states.
//  The readout also waits while a previous result is still stalled at the
//  output register. Reset clears the fill count, the overflow flag, the
//  sequencer and the output valid; the chain values need no reset.
// ----------------------------------------------------------------------------
module median_of_set_selector_top
  import mos_pkg::*;
#(
  parameter int MAX_SET    = DEF_MAX_SET,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_of_set,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_median,
  output logic [SIZE_W-1:0]          out_set_size,
  output logic                       out_overflow
);

  localparam int CW = $clog2(MAX_SET + 1);
  localparam int IW = $clog2(MAX_SET);
  localparam int NG = (MAX_SET + GRP_SIZE - 1) / GRP_SIZE;
  localparam int HW = (NG > 1) ? $clog2(NG) : 1;
  localparam int LW = $clog2(GRP_SIZE);

  mos_state_t state_r, state_nxt;

  logic [CW-1:0]                count_r;
  logic                         dropped_r;
  logic [CW-1:0]                cnt_new;
  logic                         full;
  logic                         in_acc;
  logic                         ins_en;
  logic signed [VALUE_BITS-1:0] smp;

  logic [IW-1:0]                idx_r;
  logic [CW-1:0]                size_r;
  logic                         ovf_r;
  logic [LW-1:0]                idx_lo;
  logic [HW-1:0]                idx_hi;

  logic signed [VALUE_BITS-1:0] cell_val [MAX_SET];
  logic                         cell_gt  [MAX_SET];
  logic signed [VALUE_BITS-1:0] grp_r    [NG];
  logic signed [VALUE_BITS-1:0] grp_nxt  [NG];
  logic signed [VALUE_BITS-1:0] pick;

  logic                         out_valid_r;
  logic signed [SAMPLE_W-1:0]   median_r;
  logic [SIZE_W-1:0]            set_size_r;
  logic                         overflow_r;
  logic                         out_load;

  // handshake and sample conditioning
  assign in_acc  = in_valid && !in_stall;
  assign full    = count_r == CW'(MAX_SET);
  assign ins_en  = in_acc && !full;
  assign cnt_new = full ? count_r : count_r + CW'(1);
  assign smp     = VALUE_BITS'(in_sample);

  // insertion chain
  for (genvar i = 0; i < MAX_SET; i++) begin : g_cell
    if (i == 0) begin : g_head
      mos_cell #(.IDX(i), .VALUE_BITS(VALUE_BITS), .CW(CW)) u_cell (
        .clk      (clk),
        .ins_en   (ins_en),
        .ins_val  (smp),
        .count    (count_r),
        .prev_val (smp),
        .prev_gt  (1'b0),
        .val      (cell_val[i]),
        .gt       (cell_gt[i])
      );
    end else begin : g_body
      mos_cell #(.IDX(i), .VALUE_BITS(VALUE_BITS), .CW(CW)) u_cell (
        .clk      (clk),
        .ins_en   (ins_en),
        .ins_val  (smp),
        .count    (count_r),
        .prev_val (cell_val[i-1]),
        .prev_gt  (cell_gt[i-1]),
        .val      (cell_val[i]),
        .gt       (cell_gt[i])
      );
    end
  end

  // fill count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (in_acc) begin
      if (in_last_of_set) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end else begin
        count_r   <= cnt_new;
        dropped_r <= dropped_r | full;
      end
    end
  end

  // capture readout index, size and flag at the end of a set
  always_ff @(posedge clk) begin
    if (in_acc && in_last_of_set) begin
      idx_r  <= IW'(cnt_new >> 1);
      size_r <= cnt_new;
      ovf_r  <= dropped_r | full;
    end
  end

  assign idx_lo = LW'(idx_r % GRP_SIZE);
  assign idx_hi = HW'(idx_r / GRP_SIZE);

  // readout level one: one entry per group of the chain
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if ((g * GRP_SIZE + j < MAX_SET) && (idx_lo == LW'(j))) begin
          grp_nxt[g] = cell_val[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_GRP) begin
      grp_r <= grp_nxt;
    end
  end

  // readout level two: the group
  always_comb begin
    pick = '0;
    for (int g = 0; g < NG; g++) begin
      if (idx_hi == HW'(g)) begin
        pick = grp_r[g];
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: if (in_acc && in_last_of_set) state_nxt = ST_GRP;
      ST_GRP: state_nxt = ST_SEL;
      ST_SEL: if (!out_valid_r || !out_stall) state_nxt = ST_RUN;
      default: state_nxt = ST_RUN;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      ST_RUN: in_stall = 1'b0;
      ST_GRP: in_stall = 1'b1;
      ST_SEL: out_load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_r   <= SAMPLE_W'(pick);
      set_size_r <= SIZE_W'(size_r);
      overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_median   = median_r;
  assign out_set_size = set_size_r;
  assign out_overflow = overflow_r;

`ifndef SYNTHESIS
  // the readout states after a last word hold the input off
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_of_set) |=> (in_stall ##1 in_stall))
    else $error("input taken during readout");

  // fill count stays within the chain
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SET))
    else $error("fill count beyond chain length");

  // a new result only comes out of the select step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(state_r == ST_SEL))
    else $error("result word without readout");

  // the chain is idle while a readout is in progress
  a_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !ins_en)
    else $error("insertion during readout");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the median-of-set selector against a sorted-set predictor. Sets of
// Q16.16 words stream in with random gaps. The result side stalls at random
// and holds off once for a long stretch. Each median, count and overflow flag
// is compared with the predicted one, oldest first.
// ----------------------------------------------------------------------------
module tb;
  import mos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAP        = DEF_MAX_SET;
  localparam int WORDS_WANTED   = 550;
  localparam int IDLE_LIMIT     = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_RESULT = 12;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
    int unsigned                gap;
  } sample_word_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] median;
    logic [SIZE_W-1:0]          set_size;
    logic                       overflow;
  } median_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_last_of_set = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_median;
  logic [SIZE_W-1:0]          out_set_size;
  logic                       out_overflow;

  sample_word_t   words_to_send[$];
  median_result_t medians_due[$];

  // predictor state: the current set, ascending
  logic signed [SAMPLE_W-1:0] set_sorted[$];
  bit                         set_lost = 1'b0;

  int unsigned words_total = 0;
  int unsigned words_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;

  median_of_set_selector_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_last_of_set (in_last_of_set),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median     (out_median),
    .out_set_size   (out_set_size),
    .out_overflow   (out_overflow)
  );

  always #2 clk = ~clk;

  // insert one word into the predicted set; close the set on its last word
  function automatic void fold_into_set(logic signed [SAMPLE_W-1:0] v, logic last);
    int unsigned    p;
    median_result_t r;
    if (set_sorted.size() < SET_CAP) begin
      p = set_sorted.size();
      // equal values stay ahead of the new one
      while (p > 0 && set_sorted[p-1] > v) p--;
      set_sorted.insert(p, v);
    end else begin
      set_lost = 1'b1;
    end
    if (last) begin
      r.median   = set_sorted[set_sorted.size() / 2];
      r.set_size = SIZE_W'(set_sorted.size());
      r.overflow = set_lost;
      medians_due.insert(medians_due.size(), r);
      set_sorted.delete();
      set_lost = 1'b0;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_value();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = $signed($urandom_range(0, 16)) - 8;   // clusters of equal values
      3:    v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      4:    v = $urandom & 32'hFFFF_0000;             // whole numbers
      default: v = $urandom ^ 32'h8000_0000;
    endcase
    return v;
  endfunction

  function automatic void queue_word(logic signed [SAMPLE_W-1:0] v, logic last,
                                     int unsigned gap);
    sample_word_t w;
    w.value = v;
    w.last  = last;
    w.gap   = gap;
    words_to_send.insert(words_to_send.size(), w);
    words_total++;
  endfunction

  // stimulus and end of run
  initial begin
    int unsigned set_idx;
    int unsigned set_len;
    bit          burst;

    // single values at both extremes
    queue_word(32'sh7FFF_FFFF, 1'b1, 0);
    queue_word(32'sh8000_0000, 1'b1, 1);
    // even count: upper median
    queue_word(32'sh7FFF_FFFF, 1'b0, 0);
    queue_word(32'sh8000_0000, 1'b1, 0);
    // repeated values
    queue_word(5, 1'b0, 2);
    queue_word(-3, 1'b0, 0);
    queue_word(5, 1'b0, 0);
    queue_word(5, 1'b0, 3);
    queue_word(-3, 1'b1, 0);
    // fractional Q16.16 values, even count
    queue_word(32'sh0001_0000, 1'b0, 0);
    queue_word(32'shFFFF_0000, 1'b0, 0);
    queue_word(32'sh0000_0000, 1'b0, 1);
    queue_word(32'sh0000_8000, 1'b1, 0);
    // around zero, odd count
    queue_word(-1, 1'b0, 0);
    queue_word(0, 1'b0, 0);
    queue_word(1, 1'b1, 4);

    // random sets; a full set and one that drops its flagged word come early
    set_idx = 0;
    while (words_total < WORDS_WANTED) begin
      if (set_idx == 2)                    set_len = SET_CAP;
      else if (set_idx == 5)               set_len = SET_CAP + 1;
      else if ($urandom_range(0, 11) == 0) set_len = $urandom_range(SET_CAP - 4, SET_CAP + 6);
      else                                 set_len = $urandom_range(1, 12);
      burst = ($urandom_range(0, 4) == 0);
      for (int unsigned k = 0; k < set_len; k++)
        queue_word(draw_value(), k == set_len - 1,
                   burst ? 0 : $urandom_range(0, 4));
      set_idx++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken != words_total || medians_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // input driver
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    sample_word_t w;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_sample      <= '0;
      in_last_of_set <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_into_set(in_sample, in_last_of_set);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          w = words_to_send.pop_front();
          in_valid       <= 1'b1;
          in_sample      <= w.value;
          in_last_of_set <= w.last;
          // gap stored with a word applies after it
          gap_left = w.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  int unsigned hold_left = 0;
  bit          quiet = 1'b0;
  always @(posedge clk) begin
    median_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected result: median %0d, size %0d, overflow %0b",
                   $time, out_median, out_set_size, out_overflow);
          errors++;
        end else begin
          e = medians_due.pop_front();
          if (out_median !== e.median) begin
            $display("%0t: median mismatch: expected %0d, got %0d",
                     $time, e.median, out_median);
            errors++;
          end
          if (out_set_size !== e.set_size) begin
            $display("%0t: set_size mismatch: expected %0d, got %0d",
                     $time, e.set_size, out_set_size);
            errors++;
          end
          if (out_overflow !== e.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, e.overflow, out_overflow);
            errors++;
          end
        end
        if ($urandom_range(0, 5) == 0) quiet = !quiet;
        if (results_seen == HOLD_AT_RESULT) hold_left = LONG_HOLD;
        else                                hold_left = quiet ? 0 : $urandom_range(0, 4);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without a word moving on either channel
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
